>>> hdl/sli_pkg.sv
// Shared types and constants for the sorted list insert/remove block.
// No dependencies; imported by every module of the block except sli_ram.
package sli_pkg;

  localparam int SLI_CAPACITY = 16;
  localparam int DATA_W       = 32;
  localparam int COUNT_OUT_W  = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_DONE
  } state_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    status_t                  status;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic signed [DATA_W-1:0] smallest;
    logic                     nonempty;
  } res_t;

endpackage

>>> hdl/sli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/sli_cmp.sv
// Shared signed comparator used by the search loop.
// Depends on sli_pkg for the data width.
module sli_cmp import sli_pkg::*; (
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic                     lt,
  output logic                     eq
);

  // Compare stored entry against the request value
  assign lt = (a < b);
  assign eq = (a == b);

endmodule

>>> hdl/sli_ctrl.sv
// Sequencer for the sorted list: linear search, then shift entries one slot
// at a time through the list RAM. Depends on sli_pkg.
module sli_ctrl import sli_pkg::*; #(
  parameter int CAPACITY = SLI_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_valid,
  input  op_t                         req_op,
  input  logic signed [DATA_W-1:0]    req_value,
  output logic                        busy,
  output logic                        res_valid,
  output res_t                        res,
  input  logic                        res_take,
  output logic                        mem_we,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr,
  output logic [DATA_W-1:0]           mem_wdata,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr,
  input  logic [DATA_W-1:0]           mem_rdata,
  output logic signed [DATA_W-1:0]    cmp_a,
  output logic signed [DATA_W-1:0]    cmp_b,
  input  logic                        cmp_lt,
  input  logic                        cmp_eq
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t                   state_r, state_nxt;
  op_t                      op_r, op_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            pos_r, pos_nxt;
  logic [CW-1:0]            ptr_r, ptr_nxt;
  logic signed [DATA_W-1:0] head_r, head_nxt;
  status_t                  status_r, status_nxt;
  logic [CW-1:0]            ptr_inc;
  logic [CW-1:0]            ptr_dec;
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  assign ptr_inc = ptr_r + CW'(1);
  assign ptr_dec = ptr_r - CW'(1);

  // Feed the shared comparator: stored entry against request value
  assign cmp_a = signed'(mem_rdata);
  assign cmp_b = val_r;

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    pos_r    <= pos_nxt;
    ptr_r    <= ptr_nxt;
    head_r   <= head_nxt;
    status_r <= status_nxt;
  end

  // Next state, RAM control and bookkeeping
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    ptr_nxt    = ptr_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = ptr_r[AW-1:0];
    mem_wdata  = mem_rdata;
    mem_raddr  = ptr_r[AW-1:0];
    busy       = (state_r != S_IDLE);
    res_valid  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt     = req_op;
          val_nxt    = req_value;
          status_nxt = STAT_OK;
          ptr_nxt    = '0;
          if (req_op == OP_INSERT && count_r == CW'(CAPACITY)) begin
            status_nxt = STAT_FULL;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD: begin
        // End of list reached: insert goes at the tail, remove misses
        if (ptr_r == count_r) begin
          pos_nxt = ptr_r;
          if (op_r == OP_INSERT) begin
            state_nxt = S_SH_RD;
          end else begin
            status_nxt = STAT_MISS;
            state_nxt  = S_DONE;
          end
        end else begin
          state_nxt = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (cmp_lt) begin
          ptr_nxt   = ptr_inc;
          state_nxt = S_SRCH_RD;
        end else begin
          pos_nxt = ptr_r;
          if (op_r == OP_INSERT) begin
            ptr_nxt   = count_r;
            state_nxt = S_SH_RD;
          end else if (cmp_eq) begin
            state_nxt = S_SH_RD;
          end else begin
            status_nxt = STAT_MISS;
            state_nxt  = S_DONE;
          end
        end
      end
      S_SH_RD: begin
        if (op_r == OP_INSERT) begin
          // Move entries up from the tail down to the insert slot
          if (ptr_r > pos_r) begin
            mem_raddr = ptr_dec[AW-1:0];
            state_nxt = S_SH_WR;
          end else begin
            state_nxt = S_PUT;
          end
        end else begin
          // Pull entries down over the removed slot
          if (ptr_inc < count_r) begin
            mem_raddr = ptr_inc[AW-1:0];
            state_nxt = S_SH_WR;
          end else begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_DONE;
          end
        end
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[AW-1:0];
        mem_wdata = mem_rdata;
        ptr_nxt   = (op_r == OP_INSERT) ? ptr_dec : ptr_inc;
        state_nxt = S_SH_RD;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[AW-1:0];
        mem_wdata = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Track the head entry on every write to slot zero
  always_comb begin
    head_nxt = head_r;
    if (mem_we && mem_waddr == '0) begin
      head_nxt = signed'(mem_wdata);
    end
  end

  // Build the result beat; count is truncated to the output field
  assign count_ext       = {{COUNT_OUT_W{1'b0}}, count_r};
  assign res.status      = status_r;
  assign res.entry_count = count_ext[COUNT_OUT_W-1:0];
  assign res.nonempty    = (count_r != '0);
  assign res.smallest    = (count_r != '0) ? head_r : '0;

endmodule

>>> hdl/sorted_list_insert_remove.sv
// Sorted list insert/remove, top level: sequencer, list RAM, comparator and
// output register. Depends on sli_pkg, sli_ram, sli_cmp and sli_ctrl.
//
// Keeps up to CAPACITY signed 32-bit values in ascending order. Opcode 0
// inserts ahead of the first entry that is greater or equal; opcode 1 removes
// the first equal entry. Each request returns one beat with status, count,
// smallest entry and a nonempty flag. Requests are handled one at a time:
// the list lives in a single-write, single-read RAM with registered read
// and one shared comparator, so the search takes a read state and a compare
// state per entry passed and the shift a read state and a write state per
// entry moved. in_stall stays high from acceptance until the result has
// entered the output register, which holds it while out_stall is high.
module sorted_list_insert_remove import sli_pkg::*; #(
  parameter int CAPACITY = SLI_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic signed [DATA_W-1:0]      in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [COUNT_OUT_W-1:0]        out_entry_count,
  output logic signed [DATA_W-1:0]      out_smallest,
  output logic                          out_nonempty
);

  localparam int AW = $clog2(CAPACITY);
  localparam logic [COUNT_OUT_W-1:0] CAP_OUT = COUNT_OUT_W'(CAPACITY);

  logic                     busy;
  logic                     res_valid;
  logic                     res_take;
  res_t                     res;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [DATA_W-1:0]        mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic [DATA_W-1:0]        mem_rdata;
  logic signed [DATA_W-1:0] cmp_a;
  logic signed [DATA_W-1:0] cmp_b;
  logic                     cmp_lt;
  logic                     cmp_eq;
  logic                     out_valid_r, out_valid_nxt;
  res_t                     out_res_r;

  sli_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_op    (op_t'(in_opcode)),
    .req_value (in_value),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .cmp_a     (cmp_a),
    .cmp_b     (cmp_b),
    .cmp_lt    (cmp_lt),
    .cmp_eq    (cmp_eq)
  );

  sli_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sli_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt),
    .eq (cmp_eq)
  );

  assign in_stall = busy;

  // Load the output register when it is empty or being drained
  assign res_take      = res_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = res_take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_entry_count = out_res_r.entry_count;
  assign out_smallest    = out_res_r.smallest;
  assign out_nonempty    = out_res_r.nonempty;

  // A dropped insert is only reported with the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |-> out_entry_count == CAP_OUT)
    else $error("full status with list below capacity");

  // An empty list reports zero as its smallest entry
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_nonempty |-> out_smallest == '0)
    else $error("empty list with nonzero smallest");

  // The block is busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted without going busy");

  // A new result never overwrites one still held by a stalled consumer
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !res_take)
    else $error("output register overwritten while stalled");

endmodule

>>> tb/tb.sv
// Self-checking testbench for sorted_list_insert_remove: drives insert and remove
// requests, predicts every result beat from a queue model of the list and checks it.
// Depends on sli_pkg and the sorted_list_insert_remove RTL.
module tb;
  import sli_pkg::*;

  localparam int LIST_DEPTH      = SLI_CAPACITY;
  localparam int HOLDOFF_CYCLES  = 300;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int DRAIN_CYCLES    = 2 * LIST_DEPTH + 16;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_opcode;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               out_status;
  logic [COUNT_OUT_W-1:0]   out_entry_count;
  logic signed [DATA_W-1:0] out_smallest;
  logic                     out_nonempty;

  // Model of the stored list, ascending, and the results still owed by the block
  logic signed [DATA_W-1:0] list_model[$];
  res_t                     owed_results[$];
  int                       mismatch_count;

  // Sender pacing and receiver hold-off control
  int burst_left;
  bit sender_gaps;
  bit holdoff_req;
  bit holdoff_active;
  bit fill_phase;

  sorted_list_insert_remove i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_smallest    (out_smallest),
    .out_nonempty    (out_nonempty)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one request to the list model and return the result it must produce
  function automatic res_t apply_request(op_t op, logic signed [DATA_W-1:0] val);
    res_t r;
    int   pos;
    r.status = STAT_OK;
    pos = 0;
    while (pos < list_model.size() && list_model[pos] < val) pos++;
    if (op == OP_INSERT) begin
      if (list_model.size() >= LIST_DEPTH) r.status = STAT_FULL;
      else list_model.insert(pos, val);
    end else begin
      if (pos < list_model.size() && list_model[pos] == val) list_model.delete(pos);
      else r.status = STAT_MISS;
    end
    r.entry_count = COUNT_OUT_W'(list_model.size());
    r.nonempty    = (list_model.size() > 0);
    r.smallest    = r.nonempty ? list_model[0] : '0;
    return r;
  endfunction

  // Offer one request beat, hold it until accepted, then record the expected result
  task automatic send_request(op_t op, logic signed [DATA_W-1:0] val);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (sender_gaps) gap = $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    owed_results.push_back(apply_request(op, val));
  endtask

  // Drop valid after the last accepted beat
  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Draw a value: extremes, a small pool that makes duplicates, or anything
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return '0;
          default: return -1;
        endcase
      end
      1, 2, 3: return $signed(DATA_W'($urandom_range(8))) - 4;
      default: return $signed($urandom());
    endcase
  endfunction

  // Pick the next random request; removes mostly target stored values
  task automatic make_random_request(output op_t op, output logic signed [DATA_W-1:0] val);
    int  sel;
    if (list_model.size() >= LIST_DEPTH && $urandom_range(3) == 0) fill_phase = 1'b0;
    if (list_model.size() == 0) fill_phase = 1'b1;
    if (fill_phase) op = ($urandom_range(99) < 75) ? OP_INSERT : OP_REMOVE;
    else op = ($urandom_range(99) < 75) ? OP_REMOVE : OP_INSERT;
    val = pick_value();
    if (op == OP_REMOVE && list_model.size() > 0) begin
      sel = $urandom_range(99);
      if (sel < 65) begin
        val = list_model[$urandom_range(list_model.size() - 1)];
      end else if (sel < 75 && list_model[$] != VAL_MAX) begin
        val = list_model[$] + 1;
      end
    end
  endtask

  // Receiver: stall in spans of random pattern, or hold off on request
  initial begin
    int held;
    int stall_span;
    int stall_mode;
    out_stall      = 1'b0;
    holdoff_active = 1'b0;
    stall_span     = 0;
    stall_mode     = 0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_req    = 1'b0;
        holdoff_active = 1'b1;
        out_stall     <= 1'b1;
        for (held = 1; held < HOLDOFF_CYCLES; held++) @(negedge clk);
        holdoff_active = 1'b0;
      end else begin
        if (stall_span == 0) begin
          stall_span = $urandom_range(5, 60);
          stall_mode = $urandom_range(2);
        end
        stall_span--;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(3) == 0);
          default: out_stall <= ($urandom_range(3) != 0);
        endcase
      end
    end
  end

  task automatic note_mismatch(string field, logic [DATA_W-1:0] expv, logic [DATA_W-1:0] actv);
    mismatch_count++;
    if (mismatch_count <= SHOWN_MISMATCHES)
      $display("mismatch %0d at %0t on %s: expected %0h, got %0h",
               mismatch_count, $time, field, expv, actv);
  endtask

  // Check each accepted result beat against the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        note_mismatch("unexpected beat", '0, DATA_W'(out_entry_count));
      end else begin
        want = owed_results.pop_front();
        if (out_status !== want.status)
          note_mismatch("status", DATA_W'(want.status), DATA_W'(out_status));
        if (out_entry_count !== want.entry_count)
          note_mismatch("entry_count", DATA_W'(want.entry_count), DATA_W'(out_entry_count));
        if (out_smallest !== want.smallest)
          note_mismatch("smallest", want.smallest, out_smallest);
        if (out_nonempty !== want.nonempty)
          note_mismatch("nonempty", DATA_W'(want.nonempty), DATA_W'(out_nonempty));
      end
    end
  end

  // Extremes, empty and full list, absent values and duplicates
  task automatic test_directed_cases();
    int k;
    sender_gaps = 1'b0;
    send_request(OP_REMOVE, 5);
    send_request(OP_INSERT, VAL_MAX);
    send_request(OP_INSERT, VAL_MIN);
    send_request(OP_INSERT, 0);
    send_request(OP_INSERT, -1);
    send_request(OP_INSERT, 0);
    send_request(OP_REMOVE, 100);
    send_request(OP_REMOVE, VAL_MIN);
    // fill the list to capacity
    for (k = 0; k < 12; k++) begin
      case (k % 3)
        0: send_request(OP_INSERT, 32'sh5555_5555);
        1: send_request(OP_INSERT, 32'shAAAA_AAAA);
        default: send_request(OP_INSERT, k - 6);
      endcase
    end
    send_request(OP_INSERT, 7);
    send_request(OP_REMOVE, VAL_MAX);
    // now above every entry
    send_request(OP_REMOVE, VAL_MAX);
  endtask

  // Long random run with alternating stretches of sender gaps and none
  task automatic test_mixed_traffic();
    op_t                      op;
    logic signed [DATA_W-1:0] val;
    int                       n;
    for (n = 0; n < 1500; n++) begin
      if (n % 200 == 0) sender_gaps = (n % 400 != 0);
      make_random_request(op, val);
      send_request(op, val);
    end
  endtask

  // Hold off the receiver while the sender keeps offering, so the input backs up
  task automatic test_output_holdoff();
    op_t                      op;
    logic signed [DATA_W-1:0] val;
    int                       n;
    sender_gaps = 1'b0;
    holdoff_req = 1'b1;
    while (!holdoff_active) @(posedge clk);
    for (n = 0; n < 150; n++) begin
      make_random_request(op, val);
      send_request(op, val);
    end
  endtask

  // Send in small groups and let every result come home between them
  task automatic test_quiet_drain();
    op_t                      op;
    logic signed [DATA_W-1:0] val;
    int                       grp;
    int                       n;
    sender_gaps = 1'b1;
    for (grp = 0; grp < 25; grp++) begin
      for (n = 0; n < 10; n++) begin
        make_random_request(op, val);
        send_request(op, val);
      end
      idle_input();
      while (owed_results.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_INSERT;
    in_value       = '0;
    mismatch_count = 0;
    burst_left     = 0;
    sender_gaps    = 1'b0;
    holdoff_req    = 1'b0;
    fill_phase     = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_mixed_traffic();
    test_output_holdoff();
    test_quiet_drain();

    // drain: wait for every owed result, then watch for stray beats
    idle_input();
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #(10 * 1000000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sorted_list_insert_remove.f
hdl/sli_pkg.sv
hdl/sli_ram.sv
hdl/sli_cmp.sv
hdl/sli_ctrl.sv
hdl/sorted_list_insert_remove.sv
tb/tb.sv
